// File: rtl/tcw_pkg.sv
package tcw_pkg;

    // Fixed field widths
    localparam int IDX_W  = 13;   // cell index
    localparam int CELL_W = 16;   // attribute:character
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // Defaults for the geometry parameters
    localparam int COLUMNS_DEF      = 80;
    localparam int ROWS_DEF         = 25;
    localparam int MEMORY_CELLS_DEF = 8192;

    localparam logic [CHAR_W-1:0] RESET_ATTR  = 8'h07;
    localparam logic [CELL_W-1:0] RESET_ERASE = 16'h0720;

    // Byte codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ENQ = 8'h05;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHAR_ATTR  = 1'b0,
        CFG_ERASE_WORD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_byte;
        logic [IDX_W-1:0]  read_address;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  display_start;
        logic [IDX_W-1:0]  cursor_cell;
        logic [CELL_W-1:0] read_data;
    } out_item_t;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_BS,
        CLS_DEL,
        CLS_CR,
        CLS_LF,
        CLS_PRINT
    } byte_class_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ROW_CLEAR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_TAIL_CLEAR,
        ST_PRINT,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_READ,
        DP_BACKSPACE,
        DP_DELETE,
        DP_CR,
        DP_LF_DOWN,
        DP_PRINT,
        DP_ROW_CLEAR,
        DP_COPY_RD,
        DP_COPY_WR,
        DP_TAIL_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic        is_read;
        byte_class_t cls;
        logic        col_full;
        logic        row_last;
        logic        room;
        logic        clear_last;
        logic        row_step_last;
        logic        copy_last;
    } dp_stat_t;

    function automatic byte_class_t classify(input logic [CHAR_W-1:0] ch);
        byte_class_t cls;
        unique case (ch)
            CH_NUL, CH_ENQ, CH_BEL, CH_TAB, CH_VT, CH_FF, CH_ESC: cls = CLS_IGNORE;
            CH_BS:   cls = CLS_BS;
            CH_DEL:  cls = CLS_DEL;
            CH_CR:   cls = CLS_CR;
            CH_LF:   cls = CLS_LF;
            default: cls = CLS_PRINT;
        endcase
        return cls;
    endfunction

endpackage

// File: rtl/tcw_datapath.sv
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int MEMORY_CELLS = MEMORY_CELLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  in_item_t             s_data,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CELL_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(MEMORY_CELLS);
    localparam int OFF_W = ROW_W + COL_W;

    localparam logic [IDX_W:0]   MEM_LIMIT = (IDX_W+1)'(MEMORY_CELLS);
    localparam logic [IDX_W:0]   ROOM_SPAN = (IDX_W+1)'((ROWS + 1) * COLUMNS);
    localparam logic [IDX_W-1:0] COLS_I    = IDX_W'(COLUMNS);
    localparam logic [IDX_W-1:0] SCREEN_I  = IDX_W'(ROWS * COLUMNS);
    localparam logic [IDX_W-1:0] KEEP_I    = IDX_W'((ROWS - 1) * COLUMNS);
    localparam logic [IDX_W-1:0] CLEAR_END = IDX_W'(MEMORY_CELLS - 1);
    localparam logic [IDX_W-1:0] COPY_END  = IDX_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [IDX_W-1:0] ROW_END   = IDX_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);

    logic [CELL_W-1:0] mem [MEMORY_CELLS];

    in_item_t          item_reg;
    out_item_t         out_reg;
    logic [IDX_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [CHAR_W-1:0] attr_reg;
    logic [CELL_W-1:0] erase_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              rd_ok_reg;

    logic              wr_en, wr_ok;
    logic [IDX_W-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en, rd_ok;
    logic [IDX_W:0]    rd_addr;
    logic [OFF_W-1:0]  off_cur, off_nxt;
    logic [ROW_W-1:0]  row_inc;
    logic [CELL_W-1:0] rd_value;

    assign row_inc  = row_reg + 1'b1;
    assign off_cur  = OFF_W'(row_reg) * OFF_W'(COLUMNS);
    assign off_nxt  = OFF_W'(row_inc) * OFF_W'(COLUMNS);
    assign rd_value = rd_ok_reg ? rd_data_reg : '0;
    assign wr_ok    = {1'b0, wr_addr} < MEM_LIMIT;
    assign rd_ok    = rd_addr < MEM_LIMIT;

    always_comb begin
        stat.is_read       = item_reg.req_type;
        stat.cls           = classify(item_reg.char_byte);
        stat.col_full      = col_reg >= COL_LIMIT;
        stat.row_last      = row_reg >= LAST_ROW;
        stat.room          = ({1'b0, base_reg} + ROOM_SPAN) < MEM_LIMIT;
        stat.clear_last    = cnt_reg == CLEAR_END;
        stat.row_step_last = cnt_reg == ROW_END;
        stat.copy_last     = cnt_reg == COPY_END;
    end

    always_comb begin
        base_next = base_reg;
        cur_next  = cur_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        cnt_next  = cnt_reg;
        wr_en     = 1'b0;
        wr_addr   = cur_reg;
        wr_data   = erase_reg;
        rd_en     = 1'b0;
        rd_addr   = {1'b0, item_reg.read_address};
        unique case (cmd.op)
            DP_NOP: begin
            end
            DP_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = RESET_ERASE;
                cnt_next = stat.clear_last ? '0 : cnt_reg + 1'b1;
            end
            DP_READ: begin
                rd_en = 1'b1;
            end
            DP_BACKSPACE: begin
                if (col_reg != '0) begin
                    col_next = col_reg - 1'b1;
                    cur_next = cur_reg - 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg - 1'b1;
                end
            end
            DP_DELETE: begin
                wr_en = 1'b1;
            end
            DP_CR: begin
                col_next = '0;
                cur_next = base_reg + IDX_W'(off_cur);
            end
            DP_LF_DOWN: begin
                row_next = row_inc;
                col_next = '0;
                cur_next = base_reg + IDX_W'(off_nxt);
            end
            DP_PRINT: begin
                wr_en    = 1'b1;
                wr_data  = {attr_reg, item_reg.char_byte};
                cur_next = cur_reg + 1'b1;
                col_next = col_reg + 1'b1;
            end
            DP_ROW_CLEAR: begin
                // clear the row just below the window, then slide the window
                wr_en   = 1'b1;
                wr_addr = base_reg + SCREEN_I + cnt_reg;
                if (stat.row_step_last) begin
                    cnt_next  = '0;
                    base_next = base_reg + COLS_I;
                    col_next  = '0;
                    cur_next  = base_reg + COLS_I + IDX_W'(off_cur);
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DP_COPY_RD: begin
                rd_en   = 1'b1;
                rd_addr = {1'b0, base_reg} + {1'b0, COLS_I} + {1'b0, cnt_reg};
            end
            DP_COPY_WR: begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = rd_value;
                cnt_next = stat.copy_last ? '0 : cnt_reg + 1'b1;
            end
            DP_TAIL_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = KEEP_I + cnt_reg;
                if (stat.row_step_last) begin
                    cnt_next  = '0;
                    base_next = '0;
                    row_next  = LAST_ROW;
                    col_next  = '0;
                    cur_next  = KEEP_I;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Video memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en && wr_ok) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en && rd_ok) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.load_out) begin
            out_reg.display_start <= base_reg;
            out_reg.cursor_cell   <= cur_reg;
            out_reg.read_data     <= item_reg.req_type ? rd_value : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            cur_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            attr_reg  <= RESET_ATTR;
            erase_reg <= RESET_ERASE;
        end else begin
            base_reg <= base_next;
            cur_reg  <= cur_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            cnt_reg  <= cnt_next;
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_CHAR_ATTR:  attr_reg  <= cfg_data[CHAR_W-1:0];
                    CFG_ERASE_WORD: erase_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_data = out_reg;

    a_cursor_tracks_position: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg == IDX_W'(base_reg + IDX_W'(off_cur) + IDX_W'(col_reg)))
        else $error("cursor index out of step with row/column");

    a_row_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= LAST_ROW)
        else $error("cursor row beyond last row");

    a_col_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_PRINT |=> col_reg <= COL_LIMIT && col_reg != '0)
        else $error("print left column out of range");

endmodule

// File: rtl/tcw_controller.sv
module tcw_controller
    import tcw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       pend_reg, pend_next;
    logic       take_lf, pend_set, out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pend_next      = pend_reg;
        cmd.op         = DP_NOP;
        cmd.capture    = 1'b0;
        cmd.load_out   = 1'b0;
        s_ready        = 1'b0;
        take_lf        = 1'b0;
        pend_set       = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = DP_CLEAR;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (stat.is_read) begin
                    cmd.op = DP_READ;
                end else begin
                    unique case (stat.cls)
                        CLS_IGNORE: cmd.op = DP_NOP;
                        CLS_BS:     cmd.op = DP_BACKSPACE;
                        CLS_DEL:    cmd.op = DP_DELETE;
                        CLS_CR:     cmd.op = DP_CR;
                        CLS_LF:     take_lf = 1'b1;
                        CLS_PRINT: begin
                            if (stat.col_full) begin
                                take_lf  = 1'b1;
                                pend_set = 1'b1;
                            end else begin
                                cmd.op = DP_PRINT;
                            end
                        end
                        default: cmd.op = DP_NOP;
                    endcase
                end
                if (take_lf) begin
                    pend_next = pend_set;
                    if (!stat.row_last) begin
                        cmd.op     = DP_LF_DOWN;
                        state_next = pend_set ? ST_PRINT : ST_DONE;
                    end else if (stat.room) begin
                        state_next = ST_ROW_CLEAR;
                    end else begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_ROW_CLEAR: begin
                cmd.op = DP_ROW_CLEAR;
                if (stat.row_step_last) begin
                    state_next = pend_reg ? ST_PRINT : ST_DONE;
                end
            end
            ST_COPY_RD: begin
                cmd.op     = DP_COPY_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd.op     = DP_COPY_WR;
                state_next = stat.copy_last ? ST_TAIL_CLEAR : ST_COPY_RD;
            end
            ST_TAIL_CLEAR: begin
                cmd.op = DP_TAIL_CLEAR;
                if (stat.row_step_last) begin
                    state_next = pend_reg ? ST_PRINT : ST_DONE;
                end
            end
            ST_PRINT: begin
                cmd.op     = DP_PRINT;
                pend_next  = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // publish the result and take the next word in the same cycle
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    s_ready        = 1'b1;
                    cmd.capture    = s_valid;
                    state_next     = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("input taken during memory clear");

    a_pend_only_in_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_ROW_CLEAR || state_reg == ST_COPY_RD ||
                      state_reg == ST_COPY_WR || state_reg == ST_TAIL_CLEAR ||
                      state_reg == ST_PRINT))
        else $error("pending print outside line-feed sequence");

    a_load_needs_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result overwritten before it was taken");

endmodule

// File: rtl/text_console_cell_writer.sv
// Text console cell writer: keeps a MEMORY_CELLS x 16-bit character-cell video memory
// (attribute high byte, character low byte) with a ROWS x COLUMNS window starting at
// display_start, and a cursor. Each s_ word either feeds one console byte (req_type 0)
// or reads one cell (req_type 1); each produces exactly one m_ word carrying the window
// start and cursor after the word, plus the read cell (zero for bytes and for cells past
// the end of memory). After reset the block sweeps the whole memory to 0x0720, one cell
// per cycle, so s_ready stays low until the sweep is done. Timing per word is set by the
// single write port of the video memory and a small sequencer: reads, printable bytes,
// BS, DEL, CR, ignored codes and an LF that does not scroll pass through EXEC and DONE only.
// An LF on the last row then clears the new row below the window and slides the window, or,
// when memory is exhausted, copies the screen down to cell 0 by alternating reads and
// writes and blanks the last row. A printable byte on a full line is printed in ST_PRINT after the
// line feed it triggers. The result sits in an output register, so the next word is taken
// while the previous result waits. Configuration: cfg_index 0 is the character attribute,
// 1 the erase word; cfg_ready is always high, and writes do not touch memory contents.
module text_console_cell_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int MEMORY_CELLS = MEMORY_CELLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // byte / read request words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CELL_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // registers accept a write every cycle
    assign cfg_ready = 1'b1;

    // sequencer: decodes the captured word and walks scroll/copy loops
    tcw_controller u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    // video memory, cursor/window registers, loop counter and result register
    tcw_datapath #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .MEMORY_CELLS (MEMORY_CELLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
